// ----- sv/gwf_pkg.sv -----
package gwf_pkg;

   // Default grid side and the fixed widths of the result word.
   localparam int GRID_SIDE_DEF = 16;
   localparam int OUT_POS_W     = 4;
   localparam int HEAD_W        = 2;

   // Headings.
   localparam logic [HEAD_W-1:0] DIR_NORTH = 2'd0;
   localparam logic [HEAD_W-1:0] DIR_EAST  = 2'd1;
   localparam logic [HEAD_W-1:0] DIR_SOUTH = 2'd2;
   localparam logic [HEAD_W-1:0] DIR_WEST  = 2'd3;

   // Input mode codes.
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_STEP = 1'b1;

   // Probe order of the right-hand rule: right, straight, left, back.
   localparam logic [1:0] PROBE_RIGHT    = 2'd0;
   localparam logic [1:0] PROBE_STRAIGHT = 2'd1;
   localparam logic [1:0] PROBE_LEFT     = 2'd2;
   localparam logic [1:0] PROBE_BACK     = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // write the accepted cell into the map
      logic start;      // place the walker if needed and restart the probes
      logic issue;      // read the neighbor of the next probe
      logic move;       // take the pending probe: move and turn
      logic turn_back;  // all probes blocked: only turn around
      logic finish;     // update the exit flag and load the result word
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic walk;       // an exit exists and it is not reached yet
      logic open;       // the pending probe found an open cell
      logic last;       // the pending probe is the turn-back probe
      logic out_free;   // the result register can take a word
   } status_type;

   // Heading to try for a given probe.
   function automatic logic [HEAD_W-1:0] probe_dir(input logic [HEAD_W-1:0] head,
                                                   input logic [1:0] probe);
      logic [HEAD_W-1:0] dir;
      case (probe)
         PROBE_RIGHT:    dir = head + 2'd1;
         PROBE_STRAIGHT: dir = head;
         PROBE_LEFT:     dir = head + 2'd3;
         PROBE_BACK:     dir = head + 2'd2;
         default:        dir = head;
      endcase
      return dir;
   endfunction

endpackage

// ----- sv/gwf_ctrl.sv -----
module gwf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_mode,
   output logic                 req_stall,
   input  gwf_pkg::status_type  status,
   output gwf_pkg::cmd_type     cmd
);
   import gwf_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_CHECK = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   // Words are taken only while no step is in progress.
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_LOAD) begin
                  cmd.load = 1'b1;
               end else if (status.walk) begin
                  cmd.start = 1'b1;
                  state_in  = ST_READ;
               end else begin
                  state_in  = ST_DONE;
               end
            end
         end
         ST_READ: begin
            cmd.issue = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.open) begin
               cmd.move = 1'b1;
               state_in = ST_DONE;
            end else if (status.last) begin
               cmd.turn_back = 1'b1;
               state_in      = ST_DONE;
            end else begin
               cmd.issue = 1'b1;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- sv/gwf_datapath.sv -----
module gwf_datapath #(
   parameter int GRID_SIDE = gwf_pkg::GRID_SIDE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  gwf_pkg::cmd_type                 cmd,
   output gwf_pkg::status_type              status,
   input  logic [3:0]                       req_cell_row,
   input  logic [3:0]                       req_cell_col,
   input  logic                             req_cell_is_wall,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [gwf_pkg::OUT_POS_W-1:0]    rsp_pos_row,
   output logic [gwf_pkg::OUT_POS_W-1:0]    rsp_pos_col,
   output logic [gwf_pkg::HEAD_W-1:0]       rsp_facing,
   output logic                             rsp_at_exit,
   output logic                             rsp_no_exit
);
   import gwf_pkg::*;

   localparam int POS_W     = $clog2(GRID_SIDE);
   localparam int EDGE_W    = POS_W + 1;
   localparam int MEM_DEPTH = 1 << (2 * POS_W);
   localparam int CMP_W     = 8;
   localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(GRID_SIDE - 1);
   localparam logic [EDGE_W-1:0] EDGE_NONE = EDGE_W'(GRID_SIDE);

   // Wall map, one bit per cell, addressed by row and column.
   logic                  wall_mem [MEM_DEPTH];
   logic                  rd_wall_ff;

   logic [POS_W-1:0]      cur_row_ff, cur_col_ff;
   logic [HEAD_W-1:0]     heading_ff;
   logic [EDGE_W-1:0]     entry_row_ff, exit_row_ff;
   logic                  placed_ff, reached_ff;
   logic [1:0]            probe_ff;

   // Pending probe: neighbor cell, its heading and whether it lies in the grid.
   logic [POS_W-1:0]      nb_row_ff, nb_col_ff;
   logic [HEAD_W-1:0]     nb_dir_ff;
   logic                  nb_ok_ff;
   logic                  nb_last_ff;

   logic                  rsp_valid_ff;
   logic [OUT_POS_W-1:0]  rsp_row_ff, rsp_col_ff;
   logic [HEAD_W-1:0]     rsp_facing_ff;
   logic                  rsp_at_exit_ff, rsp_no_exit_ff;

   logic                  cell_in_grid;
   logic [POS_W-1:0]      wr_row, wr_col;
   logic                  no_exit;
   logic                  at_exit_cell;
   logic [HEAD_W-1:0]     probe_head;
   logic [POS_W-1:0]      nb_row_in, nb_col_in;
   logic                  nb_ok_in;

   // Load address and range test of the incoming cell.
   assign cell_in_grid = (CMP_W'(req_cell_row) < CMP_W'(GRID_SIDE)) &&
                         (CMP_W'(req_cell_col) < CMP_W'(GRID_SIDE));
   assign wr_row = POS_W'(req_cell_row);
   assign wr_col = POS_W'(req_cell_col);

   assign no_exit      = (exit_row_ff == EDGE_NONE);
   assign at_exit_cell = (EDGE_W'(cur_row_ff) == exit_row_ff) && (cur_col_ff == LAST_POS);

   // Neighbor in the heading of the next probe; cells beyond the edge are walls.
   assign probe_head = probe_dir(heading_ff, probe_ff);
   always_comb begin
      nb_row_in = cur_row_ff;
      nb_col_in = cur_col_ff;
      nb_ok_in  = 1'b1;
      case (probe_head)
         DIR_NORTH: begin
            nb_row_in = cur_row_ff - 1'b1;
            nb_ok_in  = (cur_row_ff != '0);
         end
         DIR_EAST: begin
            nb_col_in = cur_col_ff + 1'b1;
            nb_ok_in  = (cur_col_ff != LAST_POS);
         end
         DIR_SOUTH: begin
            nb_row_in = cur_row_ff + 1'b1;
            nb_ok_in  = (cur_row_ff != LAST_POS);
         end
         DIR_WEST: begin
            nb_col_in = cur_col_ff - 1'b1;
            nb_ok_in  = (cur_col_ff != '0);
         end
         default: begin
            nb_ok_in = 1'b0;
         end
      endcase
   end

   // Map write port.
   always_ff @(posedge clock) begin
      if (cmd.load && cell_in_grid) begin
         wall_mem[{wr_row, wr_col}] <= req_cell_is_wall;
      end
   end

   // Map read port, registered.
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_wall_ff <= wall_mem[{nb_row_in, nb_col_in}];
      end
   end

   // Pending probe registers.
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         nb_row_ff  <= nb_row_in;
         nb_col_ff  <= nb_col_in;
         nb_dir_ff  <= probe_head;
         nb_ok_ff   <= nb_ok_in;
         nb_last_ff <= (probe_ff == PROBE_BACK);
      end
   end

   // Walker, edge rows and flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         heading_ff   <= DIR_EAST;
         entry_row_ff <= EDGE_NONE;
         exit_row_ff  <= EDGE_NONE;
         placed_ff    <= 1'b0;
         reached_ff   <= 1'b0;
         probe_ff     <= PROBE_RIGHT;
      end else begin
         if (cmd.load && cell_in_grid && !req_cell_is_wall) begin
            if (wr_col == '0 && EDGE_W'(wr_row) < entry_row_ff) begin
               entry_row_ff <= EDGE_W'(wr_row);
            end
            if (wr_col == LAST_POS && EDGE_W'(wr_row) < exit_row_ff) begin
               exit_row_ff <= EDGE_W'(wr_row);
            end
         end
         if (cmd.start) begin
            probe_ff <= PROBE_RIGHT;
            if (!placed_ff) begin
               cur_row_ff <= (entry_row_ff < EDGE_NONE) ? entry_row_ff[POS_W-1:0] : '0;
               cur_col_ff <= '0;
               heading_ff <= DIR_EAST;
               placed_ff  <= 1'b1;
            end
         end
         if (cmd.issue) begin
            probe_ff <= probe_ff + 1'b1;
         end
         if (cmd.move) begin
            cur_row_ff <= nb_row_ff;
            cur_col_ff <= nb_col_ff;
            heading_ff <= nb_dir_ff;
         end
         if (cmd.turn_back) begin
            heading_ff <= nb_dir_ff;
         end
         if (cmd.finish && at_exit_cell) begin
            reached_ff <= 1'b1;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_row_ff     <= OUT_POS_W'(cur_row_ff);
         rsp_col_ff     <= OUT_POS_W'(cur_col_ff);
         rsp_facing_ff  <= heading_ff;
         rsp_at_exit_ff <= reached_ff | at_exit_cell;
         rsp_no_exit_ff <= no_exit;
      end
   end

   assign status.walk     = !no_exit && !reached_ff;
   assign status.open     = nb_ok_ff && !rd_wall_ff;
   assign status.last     = nb_last_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pos_row = rsp_row_ff;
   assign rsp_pos_col = rsp_col_ff;
   assign rsp_facing  = rsp_facing_ff;
   assign rsp_at_exit = rsp_at_exit_ff;
   assign rsp_no_exit = rsp_no_exit_ff;

endmodule

// ----- sv/grid_wall_follower.sv -----
// Right-hand wall follower on a square grid.
// Input channel (req_): each word either loads one map cell (mode 0) or
// advances the walker one step (mode 1). A word is taken when req_valid is
// high and req_stall is low. A load gives no result.
// Result channel (rsp_): every step gives one word with the position, the
// heading, the sticky exit flag and the no-exit flag.
// A step runs from acceptance through the probes to the result register: the
// map has one read port, so the right, straight, left and back neighbors are
// read one per cycle behind a registered read, and probing stops at the first
// open cell. A step that cannot move (no exit, or exit reached) skips the
// probes. req_stall is high while a step is in progress, so a new word is
// taken only once the previous step has loaded its result word.
// A finished result waits in the output register while rsp_stall is high;
// loads are still taken meanwhile, and a following step completes its probes
// and then waits until the output register is free.
// Reset clears the walker to row 0, column 0, facing east, and marks entry and
// exit as unknown. The map is not cleared; every cell the walker may probe
// must be loaded first.
module grid_wall_follower #(
   parameter int GRID_SIDE = gwf_pkg::GRID_SIDE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_mode,
   input  logic [3:0] req_cell_row,
   input  logic [3:0] req_cell_col,
   input  logic       req_cell_is_wall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_pos_row,
   output logic [3:0] rsp_pos_col,
   output logic [1:0] rsp_facing,
   output logic       rsp_at_exit,
   output logic       rsp_no_exit
);
   import gwf_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Step sequencer.
   gwf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Map, walker state and result register.
   gwf_datapath #(
      .GRID_SIDE (GRID_SIDE)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_cell_row     (req_cell_row),
      .req_cell_col     (req_cell_col),
      .req_cell_is_wall (req_cell_is_wall),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pos_row      (rsp_pos_row),
      .rsp_pos_col      (rsp_pos_col),
      .rsp_facing       (rsp_facing),
      .rsp_at_exit      (rsp_at_exit),
      .rsp_no_exit      (rsp_no_exit)
   );

endmodule
